>>> rtl/uem_pkg.sv
// shared types, constants and register codes for the single-wire bus read master
package uem_pkg;

    localparam int TICK_COUNTER_BITS_DEF = 16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] READ_CMD    = 8'h03;

    localparam logic [15:0] QUARTER_TICKS_RST  = 16'd2500;
    localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd160;
    localparam logic [15:0] READ_ADDRESS_RST   = 16'd250;
    localparam logic [7:0]  READ_LENGTH_RST    = 8'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUARTER_TICKS  = 2'd0,
        CFG_DEVICE_ADDRESS = 2'd1,
        CFG_READ_ADDRESS   = 2'd2,
        CFG_READ_LENGTH    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] quarter_ticks;
        logic [7:0]  device_address;
        logic [15:0] read_address;
        logic [7:0]  read_length;
    } uem_cfg_t;

    typedef struct packed {
        logic       drive_level;
        logic       drive_enable;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] byte_position;
        logic       done_res;
        logic [2:0] status;
    } uem_res_t;

endpackage

>>> rtl/uem_cfg.sv
// configuration register file
module uem_cfg
    import uem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output uem_cfg_t              cfg_out
);

    uem_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quarter_ticks  <= QUARTER_TICKS_RST;
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.read_address   <= READ_ADDRESS_RST;
            cfg_reg.read_length    <= READ_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_QUARTER_TICKS:  cfg_reg.quarter_ticks  <= cfg_data;
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[7:0];
                CFG_READ_ADDRESS:   cfg_reg.read_address   <= cfg_data;
                CFG_READ_LENGTH:    cfg_reg.read_length    <= cfg_data[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

>>> rtl/uem_core.sv
// bus sequencer: bit timer, phase state and per-beat result logic
module uem_core
    import uem_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic     req_type,
    input  logic     bus_level,
    input  uem_cfg_t cfg,
    output uem_res_t res
);

    localparam int LW = ((TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16) + 1;
    localparam logic [LW-1:0] QCAP = LW'(1) << TICK_COUNTER_BITS;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE, PH_STANDBY, PH_HLOW, PH_TX_BIT, PH_TX_MAK,
        PH_NOSAK, PH_TX_SAK, PH_RX_BIT, PH_RX_MAK, PH_RX_SAK
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [TICK_COUNTER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]                   quarter_reg, quarter_next;
    logic [2:0]                   bit_reg, bit_next;
    logic [7:0]                   byte_reg, byte_next;
    logic [7:0]                   shift_reg, shift_next;
    logic                         fs_reg, fs_next;

    logic [LW-1:0] qlen;
    logic [LW-1:0] tick_inc;
    logic          last_tick;
    logic [3:0]    quarter_inc;
    logic [3:0]    seg_len;
    logic          seg_end;
    logic [7:0]    eff_len;
    logic          last_byte;
    logic [7:0]    tx_sel;
    logic          cur_lvl;
    logic          cur_en;
    logic          fs_s;
    logic [7:0]    shift_s;
    logic          good;

    function automatic logic manch(input logic b, input logic [2:0] q);
        return (q < 3'd2) ? ~b : b;
    endfunction

    always_comb
    begin
        qlen = LW'(cfg.quarter_ticks);
        if (qlen == '0)
            qlen = LW'(1);
        if (qlen > QCAP)
            qlen = QCAP;
        tick_inc  = LW'(tick_reg) + LW'(1);
        last_tick = (tick_inc >= qlen);

        quarter_inc = {1'b0, quarter_reg} + 4'd1;
        case (phase_reg)
            PH_WAKE:    seg_len = 4'd1;
            PH_STANDBY: seg_len = 4'd8;
            PH_HLOW:    seg_len = 4'd2;
            default:    seg_len = 4'd4;
        endcase
        seg_end = (quarter_inc >= seg_len);

        eff_len   = (cfg.read_length == 8'd0) ? 8'd1 : cfg.read_length;
        last_byte = ({1'b0, byte_reg} + 9'd1) >= {1'b0, eff_len};

        case (byte_reg)
            8'd0:    tx_sel = HEADER_BYTE;
            8'd1:    tx_sel = cfg.device_address;
            8'd2:    tx_sel = READ_CMD;
            8'd3:    tx_sel = cfg.read_address[15:8];
            default: tx_sel = cfg.read_address[7:0];
        endcase

        cur_lvl = 1'b0;
        cur_en  = 1'b1;
        case (phase_reg)
            PH_WAKE:    cur_lvl = 1'b0;
            PH_STANDBY: cur_lvl = 1'b1;
            PH_HLOW:    cur_lvl = 1'b0;
            PH_TX_BIT:  cur_lvl = manch(tx_sel[3'd7 - bit_reg], quarter_reg);
            PH_TX_MAK:  cur_lvl = manch(1'b1, quarter_reg);
            PH_RX_MAK:  cur_lvl = manch(~last_byte, quarter_reg);
            default:    cur_en  = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        quarter_next = quarter_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        fs_next      = fs_reg;
        res          = '0;
        fs_s         = fs_reg;
        shift_s      = shift_reg;
        good         = ~fs_reg & bus_level;

        if (req_type)
        begin
            res.busy_res = 1'b1;
            if (phase_reg == PH_IDLE)
            begin
                phase_next       = PH_WAKE;
                tick_next        = '0;
                quarter_next     = '0;
                bit_next         = '0;
                fs_next          = 1'b0;
                byte_next        = '0;
                shift_next       = '0;
                res.drive_level  = 1'b0;
                res.drive_enable = 1'b1;
            end
            else
            begin
                res.drive_level  = cur_lvl;
                res.drive_enable = cur_en;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            res.drive_level  = cur_lvl;
            res.drive_enable = cur_en;

            // pin sampling on the first tick of quarters 1 and 3
            if ((phase_reg == PH_TX_SAK || phase_reg == PH_RX_SAK || phase_reg == PH_RX_BIT)
                && tick_reg == '0)
            begin
                if (quarter_reg == 3'd1)
                    fs_s = bus_level;
                else if (quarter_reg == 3'd3)
                begin
                    if (phase_reg == PH_RX_BIT)
                        shift_s = {shift_reg[6:0], good};
                    else
                        fs_s = good;
                end
            end
            fs_next    = fs_s;
            shift_next = shift_s;

            if (!last_tick)
                tick_next = tick_inc[TICK_COUNTER_BITS-1:0];
            else
            begin
                tick_next    = '0;
                quarter_next = quarter_inc[2:0];
                if (seg_end)
                begin
                    quarter_next = '0;
                    case (phase_reg)
                        PH_WAKE:    phase_next = PH_STANDBY;
                        PH_STANDBY: phase_next = PH_HLOW;
                        PH_HLOW:
                        begin
                            phase_next = PH_TX_BIT;
                            bit_next   = '0;
                            byte_next  = '0;
                        end
                        PH_TX_BIT:
                        begin
                            bit_next = bit_reg + 3'd1;
                            if (bit_reg == 3'd7)
                                phase_next = PH_TX_MAK;
                        end
                        PH_TX_MAK:
                        begin
                            fs_next    = 1'b0;
                            phase_next = (byte_reg == 8'd0) ? PH_NOSAK : PH_TX_SAK;
                        end
                        PH_NOSAK:
                        begin
                            byte_next  = 8'd1;
                            bit_next   = '0;
                            phase_next = PH_TX_BIT;
                        end
                        PH_TX_SAK:
                        begin
                            if (!fs_s)
                            begin
                                res.done_res = 1'b1;
                                res.status   = byte_reg[2:0];
                                phase_next   = PH_IDLE;
                                bit_next     = '0;
                                fs_next      = 1'b0;
                            end
                            else if (byte_reg >= 8'd4)
                            begin
                                byte_next  = '0;
                                bit_next   = '0;
                                shift_next = '0;
                                fs_next    = 1'b0;
                                phase_next = PH_RX_BIT;
                            end
                            else
                            begin
                                byte_next  = byte_reg + 8'd1;
                                bit_next   = '0;
                                phase_next = PH_TX_BIT;
                            end
                        end
                        PH_RX_BIT:
                        begin
                            fs_next  = 1'b0;
                            bit_next = bit_reg + 3'd1;
                            if (bit_reg == 3'd7)
                                phase_next = PH_RX_MAK;
                        end
                        PH_RX_MAK:
                        begin
                            fs_next    = 1'b0;
                            phase_next = PH_RX_SAK;
                        end
                        PH_RX_SAK:
                        begin
                            res.byte_valid    = 1'b1;
                            res.byte_value    = fs_s ? shift_s : 8'd0;
                            res.byte_position = byte_reg;
                            if (last_byte)
                            begin
                                res.done_res = 1'b1;
                                phase_next   = PH_IDLE;
                                bit_next     = '0;
                                fs_next      = 1'b0;
                            end
                            else
                            begin
                                byte_next  = byte_reg + 8'd1;
                                shift_next = '0;
                                fs_next    = 1'b0;
                                bit_next   = '0;
                                phase_next = PH_RX_BIT;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
            res.busy_res = (phase_next != PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            quarter_reg <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            fs_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            quarter_reg <= quarter_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            fs_reg      <= fs_next;
        end
    end

endmodule

>>> rtl/uem_obuf.sv
// result register and output beat packing
module uem_obuf
    import uem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  uem_res_t              res,
    output logic                  slot_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    logic     valid_reg;
    uem_res_t res_reg;

    assign slot_free     = ~valid_reg | m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, res_reg.status, res_reg.byte_position, res_reg.byte_value,
                            res_reg.busy_res, res_reg.drive_enable, res_reg.drive_level};
    assign m_axis_tuser  = res_reg.byte_valid;
    assign m_axis_tlast  = res_reg.done_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

>>> rtl/unio_eui48_read_master.sv
// top level of the single-wire bus read master
//
// channel  | direction | beat contents
// s_axis   | in        | tuser: req_type; tdata: bus_level
// m_axis   | out       | tuser: byte_valid; tlast: done_res; tdata: drive, busy, byte, status
// cfg      | in        | cfg_index selects the register, cfg_data carries the value
//
// one input beat per clock unless the output stalls; each result comes out in the cycle after its beat
// a beat is taken whenever the result register is empty or being drained
// output stall holds the input back through s_axis_tready, nothing is dropped
// reset puts the sequencer idle and loads the register defaults
module unio_eui48_read_master
    import uem_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] bus_level
    input  logic                  s_axis_tuser,   // [0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // drive_level, drive_enable, busy_res,
                                                  // byte_value, byte_position, status
    output logic                  m_axis_tuser,   // [0] byte_valid
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    uem_cfg_t cfg;
    uem_res_t res;
    logic     slot_free;
    logic     accept;

    assign s_axis_tready = slot_free;
    assign accept        = s_axis_tvalid & slot_free;

    uem_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    uem_core #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (s_axis_tuser),
        .bus_level (s_axis_tdata[0]),
        .cfg       (cfg),
        .res       (res)
    );

    uem_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .res           (res),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> rtl/uem_checker.sv
// port-level checks on the result stream, bound to the top level
module uem_checker
    import uem_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
        else $error("done beat still shows busy");

    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0])
        else $error("released bus with nonzero drive level");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[18:3] == 16'd0)
        else $error("byte fields set without byte_valid");

    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[21:19] != 3'd0 |-> m_axis_tlast && !m_axis_tuser)
        else $error("error status outside a failed done beat");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

endmodule

bind unio_eui48_read_master uem_checker u_uem_checker (.*);

>>> tb/unio_eui48_read_master_tb.sv
// self-checking testbench for the single-wire bus read master
module unio_eui48_read_master_tb
    import uem_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BEATS = 400;
    localparam int PHASE_BEATS = 120;
    localparam int NPLAN = 26;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WAKE, ST_STANDBY, ST_HDR_LOW, ST_TX_BIT, ST_TX_MAK,
        ST_NOSAK, ST_TX_SAK, ST_RX_BIT, ST_RX_MAK, ST_RX_SAK
    } seq_state_t;

    typedef enum logic [1:0] {
        ROW_ITEM, ROW_CFG, ROW_TICKS, ROW_XFER
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        req;
        logic        lvl;
        cfg_index_t  idx;
        logic [15:0] val;
        logic [2:0]  fail;
        logic        rnd;
        logic        bad;
        logic        chk;
        uem_res_t    want;
    } plan_row_t;

    localparam uem_res_t RES_IDLE    = '0;
    localparam uem_res_t RES_WAKE    = '{1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 3'd0};
    localparam uem_res_t RES_STANDBY = '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 3'd0};

    localparam plan_row_t PLAN [NPLAN] = '{
        '{ROW_ITEM,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_IDLE},
        '{ROW_ITEM,  1'b0, 1'b1, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_QUARTER_TICKS,  16'd1,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_READ_LENGTH,    16'd1,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_ITEM,  1'b1, 1'b0, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_WAKE},
        '{ROW_ITEM,  1'b1, 1'b1, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_WAKE},
        '{ROW_ITEM,  1'b0, 1'b1, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_WAKE},
        '{ROW_ITEM,  1'b1, 1'b0, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_STANDBY},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h00A5,  3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_DEVICE_ADDRESS, 16'h00FF,  3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_READ_ADDRESS,   16'hFFFF,  3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h0000,  3'd1, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h0000,  3'd2, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h0000,  3'd3, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h0000,  3'd4, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_DEVICE_ADDRESS, 16'd0,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_READ_ADDRESS,   16'd0,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_READ_LENGTH,    16'd0,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h00FF,  3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_READ_LENGTH,    16'd2,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_XFER,  1'b0, 1'b0, CFG_QUARTER_TICKS,  16'h0000,  3'd0, 1'b0, 1'b1, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_QUARTER_TICKS,  16'hFFFF,  3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_ITEM,  1'b1, 1'b1, CFG_QUARTER_TICKS,  16'd0,     3'd0, 1'b0, 1'b0, 1'b1, RES_WAKE},
        '{ROW_TICKS, 1'b0, 1'b0, CFG_QUARTER_TICKS,  16'd200,   3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE},
        '{ROW_CFG,   1'b0, 1'b0, CFG_QUARTER_TICKS,  16'd3,     3'd0, 1'b0, 1'b0, 1'b0, RES_IDLE}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // [0] bus_level
    logic                  s_axis_tuser = 1'b0;  // [0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [0] drive_level, [1] drive_enable, [2] busy_res,
                                                 // [10:3] byte_value, [18:11] byte_position,
                                                 // [21:19] status
    logic                  m_axis_tuser;         // [0] byte_valid
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    unio_eui48_read_master dut (.*);

    // register copies
    logic [15:0] r_qt = QUARTER_TICKS_RST;
    logic [7:0]  r_dev = DEVICE_ADDRESS_RST;
    logic [15:0] r_addr = READ_ADDRESS_RST;
    logic [7:0]  r_len = READ_LENGTH_RST;

    // sequencer state
    seq_state_t  ph = ST_IDLE;
    int          tcnt = 0;
    logic [3:0]  qidx = '0;
    logic [3:0]  bidx = '0;
    logic [7:0]  bytei = '0;
    logic [7:0]  shreg = '0;
    logic        fsamp = 1'b0;

    uem_res_t    due_results [$];
    uem_res_t    got;
    uem_res_t    due;
    int          n_beats = 0;
    int          n_results = 0;
    int          n_starts = 0;
    int          n_bytes = 0;
    int          ends_by [5] = '{0, 0, 0, 0, 0};
    int          mism = 0;
    int          quiet = 0;
    int          stall_left = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;

    function automatic bit coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    function automatic int pick_gap(bit calm);
        int x;
        x = $urandom_range(0, 99);
        if (calm || x < 55)
            return 0;
        if (x < 85)
            return $urandom_range(1, 3);
        if (x < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit on_last_byte();
        int eff;
        eff = (r_len == 8'd0) ? 1 : int'(r_len);
        return int'(bytei) + 1 >= eff;
    endfunction

    function automatic void restart_counts();
        tcnt = 0;
        qidx = '0;
        bidx = '0;
        fsamp = 1'b0;
    endfunction

    // {level, enable} on the wire for the current quarter
    function automatic logic [1:0] line_drive();
        logic       b;
        logic [7:0] txb;
        b = 1'b0;
        txb = '0;
        case (ph)
            ST_WAKE, ST_HDR_LOW: return 2'b01;
            ST_STANDBY: return 2'b11;
            ST_TX_BIT:
            begin
                case (bytei)
                    8'd0: txb = HEADER_BYTE;
                    8'd1: txb = r_dev;
                    8'd2: txb = READ_CMD;
                    8'd3: txb = r_addr[15:8];
                    default: txb = r_addr[7:0];
                endcase
                b = txb[3'd7 - bidx[2:0]];
            end
            ST_TX_MAK: b = 1'b1;
            ST_RX_MAK: b = !on_last_byte();
            default: return 2'b00;
        endcase
        return {(qidx < 4'd2) ? ~b : b, 1'b1};
    endfunction

    function automatic uem_res_t sequencer_step(logic req, logic bus);
        uem_res_t   r;
        logic [1:0] de;
        int         qlen;
        int         seg;
        logic       good;
        r = '0;
        if (req)
        begin
            if (ph == ST_IDLE)
            begin
                ph = ST_WAKE;
                restart_counts();
                bytei = '0;
                shreg = '0;
            end
            de = line_drive();
            r.drive_level = de[1];
            r.drive_enable = de[0];
            r.busy_res = 1'b1;
            return r;
        end
        if (ph == ST_IDLE)
            return r;
        de = line_drive();
        r.drive_level = de[1];
        r.drive_enable = de[0];
        if ((ph == ST_TX_SAK || ph == ST_RX_SAK || ph == ST_RX_BIT) && tcnt == 0)
        begin
            if (qidx == 4'd1)
                fsamp = bus;
            else if (qidx == 4'd3)
            begin
                good = !fsamp && bus;
                if (ph == ST_RX_BIT)
                    shreg = {shreg[6:0], good};
                else
                    fsamp = good;
            end
        end
        qlen = (r_qt == 16'd0) ? 1 : int'(r_qt);
        if (tcnt + 1 < qlen)
            tcnt++;
        else
        begin
            tcnt = 0;
            qidx++;
            seg = (ph == ST_WAKE) ? 1 : (ph == ST_STANDBY) ? 8 : (ph == ST_HDR_LOW) ? 2 : 4;
            if (int'(qidx) >= seg)
            begin
                qidx = '0;
                case (ph)
                    ST_WAKE: ph = ST_STANDBY;
                    ST_STANDBY: ph = ST_HDR_LOW;
                    ST_HDR_LOW:
                    begin
                        ph = ST_TX_BIT;
                        bidx = '0;
                        bytei = '0;
                    end
                    ST_TX_BIT:
                    begin
                        bidx++;
                        if (bidx >= 4'd8)
                        begin
                            bidx = '0;
                            ph = ST_TX_MAK;
                        end
                    end
                    ST_TX_MAK:
                    begin
                        fsamp = 1'b0;
                        ph = (bytei == 8'd0) ? ST_NOSAK : ST_TX_SAK;
                    end
                    ST_NOSAK:
                    begin
                        bytei = 8'd1;
                        bidx = '0;
                        ph = ST_TX_BIT;
                    end
                    ST_TX_SAK:
                    begin
                        if (!fsamp)
                        begin
                            r.done_res = 1'b1;
                            r.status = bytei[2:0];
                            ph = ST_IDLE;
                            restart_counts();
                        end
                        else if (bytei >= 8'd4)
                        begin
                            bytei = '0;
                            bidx = '0;
                            shreg = '0;
                            fsamp = 1'b0;
                            ph = ST_RX_BIT;
                        end
                        else
                        begin
                            bytei++;
                            bidx = '0;
                            ph = ST_TX_BIT;
                        end
                    end
                    ST_RX_BIT:
                    begin
                        fsamp = 1'b0;
                        bidx++;
                        if (bidx >= 4'd8)
                        begin
                            bidx = '0;
                            ph = ST_RX_MAK;
                        end
                    end
                    ST_RX_MAK:
                    begin
                        fsamp = 1'b0;
                        ph = ST_RX_SAK;
                    end
                    default:
                    begin
                        r.byte_valid = 1'b1;
                        r.byte_value = fsamp ? shreg : 8'd0;
                        r.byte_position = bytei;
                        if (on_last_byte())
                        begin
                            r.done_res = 1'b1;
                            ph = ST_IDLE;
                            restart_counts();
                        end
                        else
                        begin
                            bytei++;
                            shreg = '0;
                            fsamp = 1'b0;
                            bidx = '0;
                            ph = ST_RX_BIT;
                        end
                    end
                endcase
            end
        end
        r.busy_res = (ph != ST_IDLE);
        return r;
    endfunction

    function automatic string fmt_res(uem_res_t r);
        return $sformatf("lvl=%b en=%b busy=%b bv=%b byte=%h pos=%0d done=%b status=%0d",
                         r.drive_level, r.drive_enable, r.busy_res, r.byte_valid,
                         r.byte_value, r.byte_position, r.done_res, r.status);
    endfunction

    // one input beat; valid stays high afterwards until the caller lowers it
    task automatic push_beat(logic req, logic lvl, logic chk, uem_res_t want);
        int       gap;
        bit       was_idle;
        uem_res_t r;
        if ($urandom_range(0, 299) == 0)
            src_calm = !src_calm;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {{(IN_DATA_W-1){1'b0}}, lvl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        was_idle = (ph == ST_IDLE);
        r = sequencer_step(req, lvl);
        due_results.push_back(chk ? want : r);
        n_beats++;
        if (req && was_idle)
            n_starts++;
        if (r.done_res && r.status <= 3'd4)
            ends_by[r.status]++;
        if (r.byte_valid)
            n_bytes++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_QUARTER_TICKS: r_qt = val;
            CFG_DEVICE_ADDRESS: r_dev = val[7:0];
            CFG_READ_ADDRESS: r_addr = val;
            default: r_len = val[7:0];
        endcase
    endtask

    // start (if idle) and tick until the sequencer is back to idle
    task automatic run_xfer(logic [2:0] fail_at, logic [7:0] data, bit rnd,
                            int bad_pct, int noise);
        logic [7:0] rx_byte;
        bit         rx_bad;
        logic       lvl;
        rx_byte = data;
        rx_bad = 1'b0;
        if (ph == ST_IDLE)
            push_beat(1'b1, coin(), 1'b0, RES_IDLE);
        while (ph != ST_IDLE)
        begin
            if (ph == ST_RX_BIT && bidx == 4'd0 && qidx == 4'd0 && tcnt == 0)
            begin
                if (rnd)
                    rx_byte = 8'($urandom);
                rx_bad = $urandom_range(0, 99) < bad_pct;
            end
            case (ph)
                ST_TX_SAK: lvl = (bytei == {5'd0, fail_at}) || (qidx >= 4'd2);
                ST_RX_SAK: lvl = rx_bad || (qidx >= 4'd2);
                ST_RX_BIT: lvl = rx_byte[3'd7 - bidx[2:0]] ^ (qidx < 4'd2);
                default: lvl = coin();
            endcase
            if ($urandom_range(0, 99) < noise)
                lvl = coin();
            if ($urandom_range(0, 199) < noise)
                push_beat(1'b1, coin(), 1'b0, RES_IDLE);
            push_beat(1'b0, lvl, 1'b0, RES_IDLE);
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // result side backpressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 299) == 0)
                sink_calm = !sink_calm;
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap(1'b0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.drive_level = m_axis_tdata[0];
            got.drive_enable = m_axis_tdata[1];
            got.busy_res = m_axis_tdata[2];
            got.byte_value = m_axis_tdata[10:3];
            got.byte_position = m_axis_tdata[18:11];
            got.status = m_axis_tdata[21:19];
            got.byte_valid = m_axis_tuser;
            got.done_res = m_axis_tlast;
            n_results++;
            if (due_results.size() == 0)
            begin
                mism++;
                if (mism <= 10)
                    $display("result beat %0d with nothing pending: %s", n_results, fmt_res(got));
            end
            else
            begin
                due = due_results.pop_front();
                if (got.drive_level !== due.drive_level || got.drive_enable !== due.drive_enable ||
                    got.busy_res !== due.busy_res || got.byte_valid !== due.byte_valid ||
                    got.byte_value !== due.byte_value ||
                    got.byte_position !== due.byte_position ||
                    got.done_res !== due.done_res || got.status !== due.status)
                begin
                    mism++;
                    if (mism <= 10)
                    begin
                        $display("result beat %0d mismatch", n_results);
                        $display("  expected %s", fmt_res(due));
                        $display("  actual   %s", fmt_res(got));
                    end
                end
            end
        end
    end

    initial
    begin
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        plan_row_t  row;
        int         goal;
        int         phase_end;
        logic [2:0] fail_at;
        int         x;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NPLAN; i++)
        begin
            row = PLAN[i];
            case (row.kind)
                ROW_ITEM: push_beat(row.req, row.lvl, row.chk, row.want);
                ROW_CFG: write_reg(row.idx, row.val);
                ROW_TICKS:
                begin
                    repeat (int'(row.val)) push_beat(1'b0, coin(), 1'b0, RES_IDLE);
                end
                default: run_xfer(row.fail, row.val[7:0], row.rnd, row.bad ? 30 : 0, 0);
            endcase
        end

        goal = n_beats + RANDOM_BEATS;
        while (n_beats < goal)
        begin
            x = $urandom_range(0, 9);
            write_reg(CFG_QUARTER_TICKS, (x < 6) ? 16'd1 : (x < 9) ? 16'd2 :
                      16'($urandom_range(3, 4)));
            write_reg(CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 255)));
            write_reg(CFG_READ_ADDRESS, 16'($urandom_range(0, 65535)));
            x = $urandom_range(0, 9);
            write_reg(CFG_READ_LENGTH, (x < 8) ? 16'($urandom_range(1, 3)) :
                      (x < 9) ? 16'($urandom_range(4, 6)) : 16'd0);
            phase_end = n_beats + PHASE_BEATS;
            while (n_beats < phase_end && n_beats < goal)
            begin
                repeat ($urandom_range(0, 2)) push_beat(1'b0, coin(), 1'b0, RES_IDLE);
                if ($urandom_range(0, 9) == 0)
                    drain_results();
                fail_at = ($urandom_range(0, 99) < 30) ? 3'($urandom_range(1, 4)) : 3'd0;
                run_xfer(fail_at, 8'd0, 1'b1, 12, 3);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d input beats, %0d results, %0d transactions, %0d data bytes",
                 n_beats, n_results, n_starts, n_bytes);
        $display("transaction ends: ok %0d, no ack after dev %0d cmd %0d addr hi %0d addr lo %0d",
                 ends_by[0], ends_by[1], ends_by[2], ends_by[3], ends_by[4]);
        if (mism == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> unio_eui48_read_master.f
rtl/uem_pkg.sv
rtl/uem_cfg.sv
rtl/uem_core.sv
rtl/uem_obuf.sv
rtl/unio_eui48_read_master.sv
rtl/uem_checker.sv
tb/unio_eui48_read_master_tb.sv
